// ===== sv/assert_macros.svh =====
// assertion macros used by the interval timer channel core
// each macro expects signals named clk and rst in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define ITC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property whose consequence is checked in the next cycle
`define ITC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/itc_pkg.sv =====
// types and codes for the interval timer channel
// no dependencies
package itc_pkg;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // port addresses
  localparam logic [1:0] PORT_DATA = 2'd0;
  localparam logic [1:0] PORT_MODE = 2'd3;

  // channel select field of a mode word for this channel
  localparam logic [1:0] SEL_CH0 = 2'd0;

  // operating mode after reset: rate generator
  localparam logic [2:0] OPMODE_RATE = 3'd2;

  // access modes
  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LOW   = 2'd1,
    ACC_HIGH  = 2'd2,
    ACC_BOTH  = 2'd3
  } acc_t;

  // one input item
  typedef struct packed {
    logic [1:0] func;
    logic [1:0] port;
    logic [7:0] write_data;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       terminal_pulse;
  } result_t;

endpackage

// ===== sv/itc_in_stage.sv =====
// input register of the interval timer channel
// depends on itc_pkg
module itc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  itc_pkg::item_t in_item,
  output logic          held_valid,
  output itc_pkg::item_t held_item,
  input  logic          advance
);

  itc_pkg::item_t item;
  logic           valid;

  // take a new transaction when empty or when the held one moves on
  assign in_ready   = !valid || advance;
  assign held_valid = valid;
  assign held_item  = item;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== sv/itc_core.sv =====
// counter channel state and single-pass step logic
// depends on itc_pkg and assert_macros.svh
`include "assert_macros.svh"

module itc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  itc_pkg::item_t   item,
  output itc_pkg::result_t result
);

  logic [15:0]        current_count, current_count_next;
  logic [15:0]        reload_value, reload_value_next;
  itc_pkg::acc_t      access_mode, access_mode_next;
  logic [2:0]         operating_mode, operating_mode_next;
  logic               write_high, write_high_next;
  logic               read_high, read_high_next;
  logic [7:0]         pending_low_byte, pending_low_byte_next;
  logic [15:0]        latched_count, latched_count_next;
  logic               latch_valid, latch_valid_next;
  logic               counting, counting_next;
  logic               commit;
  logic [15:0]        commit_value;
  logic [15:0]        read_value;

  // next state and result for the current transaction
  always_comb begin
    current_count_next    = current_count;
    reload_value_next     = reload_value;
    access_mode_next      = access_mode;
    operating_mode_next   = operating_mode;
    write_high_next       = write_high;
    read_high_next        = read_high;
    pending_low_byte_next = pending_low_byte;
    latched_count_next    = latched_count;
    latch_valid_next      = latch_valid;
    counting_next         = counting;
    commit                = 1'b0;
    commit_value          = 16'h0000;
    result                = '0;
    read_value            = latch_valid ? latched_count : current_count;
    if (en) begin
      unique case (item.func)
        itc_pkg::FUNC_TICK: begin
          // down-count, reload and pulse at terminal count
          if (counting) begin
            if (current_count == 16'd1) begin
              current_count_next    = reload_value;
              result.terminal_pulse = 1'b1;
            end else begin
              current_count_next = current_count - 16'd1;
            end
          end
        end
        itc_pkg::FUNC_WRITE: begin
          if (item.port == itc_pkg::PORT_MODE) begin
            // mode word: latch command or new access and operating mode
            if (item.write_data[7:6] == itc_pkg::SEL_CH0) begin
              if (itc_pkg::acc_t'(item.write_data[5:4]) == itc_pkg::ACC_LATCH) begin
                if (!latch_valid) begin
                  latched_count_next = current_count;
                  latch_valid_next   = 1'b1;
                end
              end else begin
                access_mode_next    = itc_pkg::acc_t'(item.write_data[5:4]);
                operating_mode_next = item.write_data[3:1];
                counting_next       = 1'b0;
                write_high_next     = 1'b0;
                read_high_next      = 1'b0;
                latch_valid_next    = 1'b0;
              end
            end
          end else if (item.port == itc_pkg::PORT_DATA) begin
            // count write
            unique case (access_mode)
              itc_pkg::ACC_LOW: begin
                commit       = 1'b1;
                commit_value = {8'h00, item.write_data};
              end
              itc_pkg::ACC_HIGH: begin
                commit       = 1'b1;
                commit_value = {item.write_data, 8'h00};
              end
              default: begin
                if (!write_high) begin
                  pending_low_byte_next = item.write_data;
                  write_high_next       = 1'b1;
                end else begin
                  write_high_next = 1'b0;
                  commit          = 1'b1;
                  commit_value    = {item.write_data, pending_low_byte};
                end
              end
            endcase
          end
        end
        itc_pkg::FUNC_READ: begin
          // counter read, latched value first
          if (item.port == itc_pkg::PORT_DATA) begin
            unique case (access_mode)
              itc_pkg::ACC_LOW: begin
                result.read_data = read_value[7:0];
                latch_valid_next = 1'b0;
              end
              itc_pkg::ACC_HIGH: begin
                result.read_data = read_value[15:8];
                latch_valid_next = 1'b0;
              end
              default: begin
                if (!read_high) begin
                  result.read_data = read_value[7:0];
                  read_high_next   = 1'b1;
                end else begin
                  result.read_data = read_value[15:8];
                  read_high_next   = 1'b0;
                  latch_valid_next = 1'b0;
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
      // complete count write starts a stopped counter
      if (commit) begin
        reload_value_next = commit_value;
        if (!counting) begin
          current_count_next = commit_value;
          counting_next      = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_count    <= 16'h0000;
      reload_value     <= 16'h0000;
      access_mode      <= itc_pkg::ACC_BOTH;
      operating_mode   <= itc_pkg::OPMODE_RATE;
      write_high       <= 1'b0;
      read_high        <= 1'b0;
      pending_low_byte <= 8'h00;
      latched_count    <= 16'h0000;
      latch_valid      <= 1'b0;
      counting         <= 1'b0;
    end else begin
      current_count    <= current_count_next;
      reload_value     <= reload_value_next;
      access_mode      <= access_mode_next;
      operating_mode   <= operating_mode_next;
      write_high       <= write_high_next;
      read_high        <= read_high_next;
      pending_low_byte <= pending_low_byte_next;
      latched_count    <= latched_count_next;
      latch_valid      <= latch_valid_next;
      counting         <= counting_next;
    end
  end

  // checks
  `ITC_ASSERT_NOW(a_pulse_at_one, result.terminal_pulse,
    counting && current_count == 16'd1 && en && item.func == itc_pkg::FUNC_TICK,
    "terminal pulse without terminal count")
  `ITC_ASSERT_NOW(a_read_only_data, result.read_data != 8'h00,
    en && item.func == itc_pkg::FUNC_READ && item.port == itc_pkg::PORT_DATA,
    "read data outside a counter read")
  `ITC_ASSERT_NEXT(a_stop_by_mode, counting && !counting_next,
    $past(en && item.func == itc_pkg::FUNC_WRITE && item.port == itc_pkg::PORT_MODE),
    "counter stopped without a mode write")

endmodule

// ===== sv/itc_out_stage.sv =====
// result register of the interval timer channel
// depends on itc_pkg
module itc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  output logic             can_load,
  input  itc_pkg::result_t load_result,
  output logic             out_valid,
  input  logic             out_ready,
  output itc_pkg::result_t out_result
);

  logic             valid;
  itc_pkg::result_t result;

  // free when empty or when the held result is taken this cycle
  assign can_load   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = result;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= load_result;
    end
  end

endmodule

// ===== sv/interval_timer_channel_top.sv =====
// top level of the interval timer channel, built from itc_in_stage, itc_core and itc_out_stage
// an accepted input transaction is held in the input register; its result is registered in the result register
// throughput: one transaction per cycle, limited only by the result port taking results
// the step logic between the input register and the result register is one pass
// reset (rst, synchronous): count and reload zero, access low then high, mode two,
// counter stopped, no latch pending, both stream stages empty
module interval_timer_channel_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] write_data
  input  logic [3:0] s_tuser,   // [1:0] func, [3:2] port
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] read_data
  output logic       m_tuser    // [0] terminal_pulse
);

  itc_pkg::item_t   in_item;
  itc_pkg::item_t   held_item;
  itc_pkg::result_t step_result;
  itc_pkg::result_t out_result;
  logic             held_valid;
  logic             out_free;
  logic             advance;

  // unpack the input transaction
  assign in_item.func       = s_tuser[1:0];
  assign in_item.port       = s_tuser[3:2];
  assign in_item.write_data = s_tdata;

  // the held item is processed when the result register can take it
  assign advance = held_valid && out_free;

  itc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  itc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (held_item),
    .result (step_result)
  );

  itc_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .can_load    (out_free),
    .load_result (step_result),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result)
  );

  // pack the result transaction
  assign m_tdata = out_result.read_data;
  assign m_tuser = out_result.terminal_pulse;

endmodule
